FILE: src/flow_table_counter_defines.svh
// Assertion macros for the flow table counter.
// Each use expects clk and arst_n in scope.
`ifndef FLOW_TABLE_COUNTER_DEFINES_SVH
`define FLOW_TABLE_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS
`define FTC_ASSERT(lbl, cond, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define FTC_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define FTC_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FTC_ASSERT(lbl, cond, msg)
`define FTC_ASSERT_IMP(lbl, ante, cons, msg)
`define FTC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: src/ftc_pkg.sv
package ftc_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int FIDX_W        = 10;
	localparam int PKT_W         = 32;
	localparam int BYTE_W        = 48;
	localparam int LEN_W         = 18;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	typedef enum logic [1:0] {
		STATUS_HIT     = 2'd0,
		STATUS_NEW     = 2'd1,
		STATUS_FULL    = 2'd2,
		STATUS_IGNORED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CRD,
		ST_UPD,
		ST_EMIT
	} back_state_t;

	typedef struct packed {
		logic [63:0] addr;  // src, dst
		logic [32:0] pp;    // udp, src port, dst port
	} key_t;

	typedef struct packed {
		logic             ign;
		key_t             key;
		logic [LEN_W-1:0] len;
	} job_t;

	typedef struct packed {
		logic [BYTE_W-1:0] bytes;
		logic [PKT_W-1:0]  pkt;
		logic [FIDX_W-1:0] idx;
		status_t           status;
	} result_t;

	function automatic logic [FIDX_W-1:0] to_fidx(logic [IDX_W-1:0] i);
		logic [IDX_W+FIDX_W-1:0] w;
		w = {{FIDX_W{1'b0}}, i};
		return w[FIDX_W-1:0];
	endfunction

endpackage

FILE: src/ftc_front.sv
module ftc_front import ftc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [127:0] in_data,
	output logic         job_valid,
	input  logic         job_ready,
	output job_t         job
);

	logic         vld_q;
	logic [121:0] data_q;
	logic [7:0]   proto;

	assign in_ready  = !vld_q || job_ready;
	assign job_valid = vld_q;
	assign proto     = data_q[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= in_data[121:0];
		end
	end

	always_comb begin
		unique case (proto)
			PROTO_TCP, PROTO_UDP: job.ign = 1'b0;
			default:              job.ign = 1'b1;
		endcase
		job.key.addr = {data_q[39:8], data_q[87:56]};
		job.key.pp   = {proto == PROTO_UDP, data_q[55:40], data_q[103:88]};
		job.len      = data_q[121:104];
	end

endmodule

FILE: src/ftc_queue.sv
module ftc_queue import ftc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_job,
	output logic rd_valid,
	input  logic rd_pop,
	output job_t rd_job
);

	job_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_job   = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (rd_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(rd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_job;
		end
	end

endmodule

FILE: src/ftc_back.sv
`include "flow_table_counter_defines.svh"

module ftc_back import ftc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    job_valid,
	output logic    job_pop,
	input  job_t    job,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	key_t                      key_mem [TABLE_ENTRIES];
	logic [PKT_W+BYTE_W-1:0]   cnt_mem [TABLE_ENTRIES];

	back_state_t               state_q, state_d;
	job_t                      job_q;
	result_t                   res_q, out_q;
	logic                      out_vld_q;
	logic [CNT_W-1:0]          used_q;
	logic [CNT_W-1:0]          scan_q;
	logic [IDX_W-1:0]          idx_q;
	logic                      rvld_s1;
	logic [IDX_W-1:0]          raddr_s1;
	key_t                      rkey_s1;
	logic [PKT_W+BYTE_W-1:0]   cnt_s1;

	logic                      hit, issue, miss, full, alloc, load;
	logic [PKT_W-1:0]          pkt_new;
	logic [BYTE_W:0]           byte_sum;
	logic [BYTE_W-1:0]         byte_new;
	logic                      cnt_we;
	logic [IDX_W-1:0]          cnt_wa;
	logic [PKT_W+BYTE_W-1:0]   cnt_wd;

	always_comb begin
		hit   = rvld_s1 && (rkey_s1 == job_q.key);
		issue = (state_q == ST_SCAN) && !hit && (scan_q < used_q);
		miss  = (state_q == ST_SCAN) && !hit && !issue && !rvld_s1;
		full  = used_q == CNT_W'(TABLE_ENTRIES);
		alloc = miss && !full;
		load  = (state_q == ST_EMIT) && (!out_vld_q || res_ready);

		pkt_new  = (cnt_s1[PKT_W-1:0] == '1) ? cnt_s1[PKT_W-1:0]
			: cnt_s1[PKT_W-1:0] + PKT_W'(1);
		byte_sum = {1'b0, cnt_s1[PKT_W+BYTE_W-1:PKT_W]} + (BYTE_W+1)'(job_q.len);
		byte_new = byte_sum[BYTE_W] ? '1 : byte_sum[BYTE_W-1:0];

		cnt_we = alloc || (state_q == ST_UPD);
		cnt_wa = alloc ? used_q[IDX_W-1:0] : idx_q;
		cnt_wd = alloc ? {BYTE_W'(job_q.len), PKT_W'(1)} : {byte_new, pkt_new};

		job_pop = 1'b0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = job.ign ? ST_EMIT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit) state_d = ST_CRD;
				else if (miss) state_d = ST_EMIT;
			end
			ST_CRD:  state_d = ST_UPD;
			ST_UPD:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			used_q    <= '0;
			scan_q    <= '0;
			rvld_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rvld_s1 <= issue;
			if (job_pop) scan_q <= '0;
			else if (issue) scan_q <= scan_q + CNT_W'(1);
			if (alloc) used_q <= used_q + CNT_W'(1);
			if (load) out_vld_q <= 1'b1;
			else if (res_ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
			res_q <= '{bytes: '0, pkt: '0, idx: '0, status: STATUS_IGNORED};
		end
		if (issue) begin
			rkey_s1  <= key_mem[scan_q[IDX_W-1:0]];
			raddr_s1 <= scan_q[IDX_W-1:0];
		end
		if (hit && state_q == ST_SCAN) idx_q <= raddr_s1;
		if (miss && full) begin
			res_q <= '{bytes: '0, pkt: '0, idx: '0, status: STATUS_FULL};
		end
		if (alloc) begin
			key_mem[used_q[IDX_W-1:0]] <= job_q.key;
			res_q <= '{bytes: BYTE_W'(job_q.len), pkt: PKT_W'(1),
				idx: to_fidx(used_q[IDX_W-1:0]), status: STATUS_NEW};
		end
		if (state_q == ST_CRD) cnt_s1 <= cnt_mem[idx_q];
		if (state_q == ST_UPD) begin
			res_q <= '{bytes: byte_new, pkt: pkt_new, idx: to_fidx(idx_q),
				status: STATUS_HIT};
		end
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		if (load) out_q <= res_q;
	end

	assign res_valid = out_vld_q;
	assign res       = out_q;

	`FTC_ASSERT(a_used_bound, used_q <= CNT_W'(TABLE_ENTRIES), "fill count past table size")
	`FTC_ASSERT_IMP(a_read_in_use, rvld_s1, CNT_W'(raddr_s1) < used_q, "scan read beyond fill")
	`FTC_ASSERT_IMP(a_pop_idle, job_pop, state_q == ST_IDLE, "job taken while busy")
	`FTC_ASSERT_NXT(a_alloc_inc, alloc, used_q == CNT_W'($past(used_q) + CNT_W'(1)), "fill count slip")
	`FTC_ASSERT_IMP(a_no_scan_hit_full, hit, !miss, "hit and miss together")

endmodule

FILE: src/flow_table_counter.sv
// Channel | Direction | Beat contents
// s_*     | in        | header: protocol, addresses, ports, captured length
// m_*     | out       | tuser status; tdata flow index, packet and byte counts
// One result beat per header beat, in order. Result time is set by the key scan, one
// stored key per cycle through the key memory read port: a matched flow at index k reads
// k + 1 keys, a new or full result reads all n flows in use, and a non-TCP/UDP header
// skips the scan.
// Reset clears the fill count, not the key or count memories; no clearing pass. Input and result sides
// stall independently via the front register, two-beat queue and output register.
module flow_table_counter import ftc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // ip_protocol, src_address, src_port, dst_address,
	                               // dst_port, captured_length, zero fill
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,  // flow_index, packet_count, byte_count, zero fill
	output logic [1:0]   m_tuser   // status
);

	logic    f_valid, f_ready, q_valid, q_pop;
	job_t    f_job, q_job;
	result_t res;

	ftc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job       (f_job)
	);

	ftc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_job   (f_job),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_job   (q_job)
	);

	ftc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job_pop   (q_pop),
		.job       (q_job),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tuser = res.status;
	assign m_tdata = {6'd0, res.bytes, res.pkt, res.idx};

endmodule
